>>> sv/ncch_pkg.sv
`default_nettype none
package ncch_pkg;

    localparam int NUM_ROUNDS = 10;

    typedef enum logic [2:0] {
        REG_KEY_X_HIGH       = 3'd0,
        REG_KEY_X_LOW        = 3'd1,
        REG_KEY_Y_HIGH       = 3'd2,
        REG_KEY_Y_LOW        = 3'd3,
        REG_PARTITION_NUMBER = 3'd4,
        REG_SECTION_CODE     = 3'd5,
        REG_START_BLOCK      = 3'd6,
        REG_KEY_MODE         = 3'd7
    } reg_index_t;

    localparam logic [1:0] MODE_ZERO_KEY  = 2'd1;
    localparam logic [1:0] MODE_SCRAMBLED = 2'd2;

    localparam logic [127:0] SCRAMBLE_C = 128'hFF3407CC3D6854F0A24D5D68E4A67C4C;

    localparam logic [7:0] RCON [NUM_ROUNDS] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
    };

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    typedef struct packed {
        logic [127:0] st;
        logic [127:0] rk;
        logic [127:0] data;
        logic [4:0]   cnt;
        logic         pass;
    } ncch_stage_t;

    function automatic logic [7:0] xtime(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // byte 0 sits in the top bits
    function automatic logic [127:0] sub_shift(input logic [127:0] s);
        logic [127:0] t;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int i = 0; i < 4; i++) begin
                t[127 - 8 * (i + 4 * c) -: 8] = SBOX[s[127 - 8 * (i + 4 * ((c + i) % 4)) -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [127:0] mix_columns(input logic [127:0] t);
        logic [127:0] m;
        logic [7:0] p0, p1, p2, p3, all;
        m = '0;
        for (int c = 0; c < 4; c++) begin
            p0 = t[127 - 32 * c -: 8];
            p1 = t[119 - 32 * c -: 8];
            p2 = t[111 - 32 * c -: 8];
            p3 = t[103 - 32 * c -: 8];
            all = p0 ^ p1 ^ p2 ^ p3;
            m[127 - 32 * c -: 8] = p0 ^ all ^ xtime(p0 ^ p1);
            m[119 - 32 * c -: 8] = p1 ^ all ^ xtime(p1 ^ p2);
            m[111 - 32 * c -: 8] = p2 ^ all ^ xtime(p2 ^ p3);
            m[103 - 32 * c -: 8] = p3 ^ all ^ xtime(p3 ^ p0);
        end
        return m;
    endfunction

    function automatic logic [127:0] key_step(input logic [127:0] rk, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, tmp;
        w0 = rk[127:96];
        w1 = rk[95:64];
        w2 = rk[63:32];
        w3 = rk[31:0];
        tmp = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ tmp;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage
`default_nettype wire

>>> sv/ncch_aes_ctr_decryptor.sv
// each accepted word goes through stage_reg 0 to 9, then the result register
// throughput: one word per cycle, set by the ten-stage aes round pipeline
// the whole pipeline moves together; it holds while the result waits under stall
// reset (rst_n low, asynchronous) clears the config registers, counter,
// working key and all stage valid bits; section code resets to 1
`default_nettype none
module ncch_aes_ctr_decryptor (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [63:0] cfg_wdata,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [63:0] block_high,
    input  wire logic [63:0] block_low,
    input  wire logic [4:0]  valid_bytes,
    input  wire logic        restart,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [63:0]      result_high,
    output logic [63:0]      result_low,
    output logic [4:0]       result_bytes
);
    import ncch_pkg::*;

    logic [63:0]  key_x_high_reg, key_x_low_reg, key_y_high_reg, key_y_low_reg;
    logic [63:0]  partition_reg;
    logic [1:0]   section_reg;
    logic [39:0]  start_block_reg;
    logic [1:0]   key_mode_reg;
    logic [127:0] counter_reg, counter_next;
    logic [127:0] wkey_reg, wkey_next;

    ncch_stage_t  stage_reg [NUM_ROUNDS];
    logic         stage_vld_reg [NUM_ROUNDS];
    ncch_stage_t  round_q [NUM_ROUNDS];
    ncch_stage_t  entry;
    logic [127:0] res_reg, res_next;
    logic [4:0]   cnt_reg;
    logic         out_vld_reg;

    logic         advance;
    logic         accept;
    logic [127:0] ctr_load, ctr_cur, key_cur, scr_a, scr_b, key_scr;
    logic [64:0]  low_sum;
    logic [127:0] ks_data;

    assign advance  = !out_vld_reg || !out_stall;
    assign in_stall = !advance;
    assign accept   = in_valid && advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_x_high_reg  <= '0;
            key_x_low_reg   <= '0;
            key_y_high_reg  <= '0;
            key_y_low_reg   <= '0;
            partition_reg   <= '0;
            section_reg     <= 2'd1;
            start_block_reg <= '0;
            key_mode_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_addr))
                REG_KEY_X_HIGH:       key_x_high_reg  <= cfg_wdata;
                REG_KEY_X_LOW:        key_x_low_reg   <= cfg_wdata;
                REG_KEY_Y_HIGH:       key_y_high_reg  <= cfg_wdata;
                REG_KEY_Y_LOW:        key_y_low_reg   <= cfg_wdata;
                REG_PARTITION_NUMBER: partition_reg   <= cfg_wdata;
                REG_SECTION_CODE:     section_reg     <= cfg_wdata[1:0];
                REG_START_BLOCK:      start_block_reg <= cfg_wdata[39:0];
                REG_KEY_MODE:         key_mode_reg    <= cfg_wdata[1:0];
                default:              key_mode_reg    <= key_mode_reg;
            endcase
        end
    end

    // counter load and key scrambler
    always_comb
    begin
        low_sum  = {1'b0, 6'd0, section_reg, 56'd0} + {25'd0, start_block_reg};
        ctr_load = {partition_reg + {63'd0, low_sum[64]}, low_sum[63:0]};
        scr_a    = {key_x_high_reg, key_x_low_reg};
        scr_a    = {scr_a[125:0], scr_a[127:126]} ^ {key_y_high_reg, key_y_low_reg};
        scr_b    = scr_a + SCRAMBLE_C;
        key_scr  = {scr_b[40:0], scr_b[127:41]};
        ctr_cur  = restart ? ctr_load : counter_reg;
        if (!restart)
        begin
            key_cur = wkey_reg;
        end
        else if (key_mode_reg == MODE_SCRAMBLED)
        begin
            key_cur = key_scr;
        end
        else
        begin
            key_cur = '0;
        end
        counter_next = ctr_cur + 128'd1;
        wkey_next    = key_cur;
        entry.st   = ctr_cur ^ key_cur;
        entry.rk   = key_cur;
        entry.data = {block_high, block_low};
        entry.cnt  = valid_bytes;
        entry.pass = !(key_mode_reg == MODE_ZERO_KEY || key_mode_reg == MODE_SCRAMBLED);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            counter_reg <= '0;
            wkey_reg    <= '0;
        end
        else if (accept)
        begin
            counter_reg <= counter_next;
            wkey_reg    <= wkey_next;
        end
    end

    genvar r;
    generate
        for (r = 1; r <= NUM_ROUNDS; r++)
        begin : g_round
            ncch_round #(.FINAL(r == NUM_ROUNDS)) u_round (
                .d  (stage_reg[r - 1]),
                .rc (RCON[r - 1]),
                .q  (round_q[r - 1])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ROUNDS; i++)
            begin
                stage_vld_reg[i] <= 1'b0;
            end
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            stage_vld_reg[0] <= in_valid;
            for (int i = 1; i < NUM_ROUNDS; i++)
            begin
                stage_vld_reg[i] <= stage_vld_reg[i - 1];
            end
            out_vld_reg <= stage_vld_reg[NUM_ROUNDS - 1];
        end
    end

    // keystream xor (skipped in pass mode) and byte mask
    always_comb
    begin
        ks_data = round_q[NUM_ROUNDS - 1].data;
        if (!round_q[NUM_ROUNDS - 1].pass)
        begin
            ks_data = ks_data ^ round_q[NUM_ROUNDS - 1].st;
        end
        for (int i = 0; i < 16; i++)
        begin
            res_next[127 - 8 * i -: 8] = (5'(i) < round_q[NUM_ROUNDS - 1].cnt) ?
                                         ks_data[127 - 8 * i -: 8] : 8'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            stage_reg[0] <= entry;
            for (int i = 1; i < NUM_ROUNDS; i++)
            begin
                stage_reg[i] <= round_q[i - 1];
            end
            res_reg <= res_next;
            cnt_reg <= round_q[NUM_ROUNDS - 1].cnt;
        end
    end

    assign out_valid    = out_vld_reg;
    assign result_high  = res_reg[127:64];
    assign result_low   = res_reg[63:0];
    assign result_bytes = cnt_reg;
endmodule
`default_nettype wire

>>> sv/ncch_round.sv
`default_nettype none
module ncch_round #(
    parameter bit FINAL = 1'b0
) (
    input  wire ncch_pkg::ncch_stage_t d,
    input  wire logic [7:0]            rc,
    output ncch_pkg::ncch_stage_t      q
);
    import ncch_pkg::*;

    logic [127:0] rk_new;
    logic [127:0] t;

    always_comb
    begin
        rk_new = key_step(d.rk, rc);
        t = sub_shift(d.st);
        if (!FINAL)
        begin
            t = mix_columns(t);
        end
        q = d;
        q.st = t ^ rk_new;
        q.rk = rk_new;
    end
endmodule
`default_nettype wire
